[rtl/scmd_pkg.sv]
//------------------------------------------------------------------------------
// SD SPI command engine package
// Shared widths, register indexes, phase encoding and the frame byte selector.
//------------------------------------------------------------------------------
`default_nettype none

package scmd_pkg;

  localparam int WAIT_COUNT_BITS = 24;
  localparam int TIMEOUT_W       = 24;
  localparam int RETRY_W         = 8;
  localparam int CMD_W           = 6;
  localparam int ARG_W           = 32;
  localparam int BYTE_W          = 8;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 24;
  localparam int FRAME_IDX_W     = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_READY_TIMEOUT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE_RETRIES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STUFF_COMMAND    = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [TIMEOUT_W-1:0] READY_TIMEOUT_RST    = 24'hFF_FFFF;
  localparam logic [RETRY_W-1:0]   RESPONSE_RETRIES_RST = 8'h1F;
  localparam logic [CMD_W-1:0]     STUFF_COMMAND_RST    = 6'd12;

  // Input word function codes.
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_RX    = 1'b1;

  // Result word kinds.
  localparam logic KIND_EXCHANGE = 1'b0;
  localparam logic KIND_FINISH   = 1'b1;

  localparam logic [BYTE_W-1:0] IDLE_BYTE   = 8'hFF;
  localparam logic [BYTE_W-1:0] START_BITS  = 8'h40;
  localparam logic [FRAME_IDX_W-1:0] FRAME_LAST_IDX = 3'd5;

  typedef enum logic [2:0] {
    PH_IDLE          = 3'd0,
    PH_PRE_DESELECT  = 3'd1,
    PH_WAIT_READY    = 3'd2,
    PH_FRAME         = 3'd3,
    PH_STUFF         = 3'd4,
    PH_R1            = 3'd5,
    PH_FAIL_DESELECT = 3'd6
  } phase_t;

  // Byte of the six-byte command frame at the given position.
  function automatic logic [BYTE_W-1:0] frame_byte(
    input logic [CMD_W-1:0]       cmd,
    input logic [ARG_W-1:0]       arg,
    input logic [BYTE_W-1:0]      crc,
    input logic [FRAME_IDX_W-1:0] idx
  );
    logic [BYTE_W-1:0] b;
    case (idx)
      3'd0: b = {2'b00, cmd} | START_BITS;
      3'd1: b = arg[31:24];
      3'd2: b = arg[23:16];
      3'd3: b = arg[15:8];
      3'd4: b = arg[7:0];
      default: b = crc;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[rtl/scmd_if.sv]
//------------------------------------------------------------------------------
// SD SPI command engine channels
// Valid/ready channels for request words and result words.
//------------------------------------------------------------------------------
`default_nettype none

interface scmd_in_if;
  import scmd_pkg::*;

  logic                valid;
  logic                ready;
  logic                func;
  logic [CMD_W-1:0]    cmd_index;
  logic [ARG_W-1:0]    argument;
  logic [BYTE_W-1:0]   crc_byte;
  logic [BYTE_W-1:0]   rx_byte;

  modport source (output valid, func, cmd_index, argument, crc_byte, rx_byte,
                  input ready);
  modport sink   (input valid, func, cmd_index, argument, crc_byte, rx_byte,
                  output ready);
endinterface

interface scmd_out_if;
  import scmd_pkg::*;

  logic                valid;
  logic                ready;
  logic                kind;
  logic [BYTE_W-1:0]   tx_byte;
  logic                chip_select_high;
  logic [BYTE_W-1:0]   r1_response;
  logic                select_failed;

  modport source (output valid, kind, tx_byte, chip_select_high, r1_response,
                  select_failed, input ready);
  modport sink   (input valid, kind, tx_byte, chip_select_high, r1_response,
                  select_failed, output ready);
endinterface

`default_nettype wire

[rtl/sd_spi_command_transaction_core.sv]
//------------------------------------------------------------------------------
// SD SPI command transaction core
// Byte-level host engine that frames one SD command and collects its R1 reply.
//------------------------------------------------------------------------------
// The core takes one word per clock while the result side keeps up. A start
// word latches the command and answers with a dummy 0xFF exchange with the
// card deselected; each received byte word then yields the next exchange (or
// the finished word), held in a single output register and shown in the
// cycle after the word is taken. A new word is taken whenever that register
// is empty or being read, so the sustained rate is one word per cycle; only a
// stalled result side slows it. Received bytes that arrive while no
// transaction runs are dropped without a result.
`default_nettype none

module sd_spi_command_transaction_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [scmd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [scmd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  scmd_in_if.sink                               in_ch,
  scmd_out_if.source                            out_ch
);
  import scmd_pkg::*;

  // Configuration registers.
  logic [TIMEOUT_W-1:0] ready_timeout_r;
  logic [RETRY_W-1:0]   response_retries_r;
  logic [CMD_W-1:0]     stuff_command_r;

  // Transaction state.
  phase_t                     phase_r, phase_nxt;
  logic [FRAME_IDX_W-1:0]     frame_idx_r, frame_idx_nxt;
  logic [WAIT_COUNT_BITS-1:0] busy_cnt_r, busy_cnt_nxt;
  logic [RETRY_W-1:0]         retries_r, retries_nxt;
  logic [CMD_W-1:0]           cmd_r, cmd_nxt;
  logic [ARG_W-1:0]           arg_r, arg_nxt;
  logic [BYTE_W-1:0]          crc_r, crc_nxt;
  logic                       sel_r, sel_nxt;

  // Result register.
  logic              out_valid_r;
  logic              kind_r, kind_nxt;
  logic [BYTE_W-1:0] tx_r, tx_nxt;
  logic              cs_r, cs_nxt;
  logic [BYTE_W-1:0] r1_r, r1_nxt;
  logic              fail_r, fail_nxt;
  logic              res_valid;

  logic                       in_acc;
  logic [WAIT_COUNT_BITS:0]   busy_inc;
  logic [WAIT_COUNT_BITS-1:0] poll_limit;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign out_ch.valid            = out_valid_r;
  assign out_ch.kind             = kind_r;
  assign out_ch.tx_byte          = tx_r;
  assign out_ch.chip_select_high = cs_r;
  assign out_ch.r1_response      = r1_r;
  assign out_ch.select_failed    = fail_r;

  // A timeout of zero counts as a single poll.
  assign poll_limit = (ready_timeout_r == '0) ? WAIT_COUNT_BITS'(1)
                                              : WAIT_COUNT_BITS'(ready_timeout_r);
  assign busy_inc   = {1'b0, busy_cnt_r} + (WAIT_COUNT_BITS+1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_timeout_r    <= READY_TIMEOUT_RST;
      response_retries_r <= RESPONSE_RETRIES_RST;
      stuff_command_r    <= STUFF_COMMAND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_READY_TIMEOUT:    ready_timeout_r    <= cfg_wdata[TIMEOUT_W-1:0];
        CFG_RESPONSE_RETRIES: response_retries_r <= cfg_wdata[RETRY_W-1:0];
        CFG_STUFF_COMMAND:    stuff_command_r    <= cfg_wdata[CMD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    frame_idx_nxt = frame_idx_r;
    busy_cnt_nxt  = busy_cnt_r;
    retries_nxt   = retries_r;
    cmd_nxt       = cmd_r;
    arg_nxt       = arg_r;
    crc_nxt       = crc_r;
    sel_nxt       = sel_r;
    res_valid     = 1'b0;
    kind_nxt      = KIND_EXCHANGE;
    tx_nxt        = IDLE_BYTE;
    cs_nxt        = 1'b0;
    r1_nxt        = '0;
    fail_nxt      = 1'b0;

    if (in_acc) begin
      if (in_ch.func == FUNC_START) begin
        // A start always restarts, even in the middle of a transaction.
        cmd_nxt       = in_ch.cmd_index;
        arg_nxt       = in_ch.argument;
        crc_nxt       = in_ch.crc_byte;
        frame_idx_nxt = '0;
        busy_cnt_nxt  = '0;
        retries_nxt   = '0;
        phase_nxt     = PH_PRE_DESELECT;
        res_valid     = 1'b1;
        cs_nxt        = 1'b1;
      end else begin
        case (phase_r)
          PH_PRE_DESELECT: begin
            phase_nxt    = PH_WAIT_READY;
            busy_cnt_nxt = '0;
            res_valid    = 1'b1;
          end
          PH_WAIT_READY: begin
            res_valid = 1'b1;
            if (in_ch.rx_byte == IDLE_BYTE) begin
              phase_nxt     = PH_FRAME;
              frame_idx_nxt = '0;
              tx_nxt        = frame_byte(cmd_r, arg_r, crc_r, '0);
            end else begin
              busy_cnt_nxt = busy_inc[WAIT_COUNT_BITS-1:0];
              if (busy_inc >= {1'b0, poll_limit}) begin
                phase_nxt = PH_FAIL_DESELECT;
                cs_nxt    = 1'b1;
              end
            end
          end
          PH_FRAME: begin
            res_valid = 1'b1;
            if (frame_idx_r < FRAME_LAST_IDX) begin
              frame_idx_nxt = frame_idx_r + FRAME_IDX_W'(1);
              tx_nxt        = frame_byte(cmd_r, arg_r, crc_r,
                                         frame_idx_r + FRAME_IDX_W'(1));
            end else if (cmd_r == stuff_command_r) begin
              phase_nxt = PH_STUFF;
            end else begin
              phase_nxt   = PH_R1;
              retries_nxt = response_retries_r;
            end
          end
          PH_STUFF: begin
            res_valid   = 1'b1;
            phase_nxt   = PH_R1;
            retries_nxt = response_retries_r;
          end
          PH_R1: begin
            res_valid = 1'b1;
            if (!in_ch.rx_byte[BYTE_W-1] || retries_r == '0) begin
              phase_nxt = PH_IDLE;
              kind_nxt  = KIND_FINISH;
              tx_nxt    = '0;
              cs_nxt    = sel_r;
              r1_nxt    = in_ch.rx_byte;
            end else begin
              retries_nxt = retries_r - RETRY_W'(1);
            end
          end
          PH_FAIL_DESELECT: begin
            res_valid = 1'b1;
            phase_nxt = PH_IDLE;
            kind_nxt  = KIND_FINISH;
            tx_nxt    = '0;
            cs_nxt    = sel_r;
            r1_nxt    = IDLE_BYTE;
            fail_nxt  = 1'b1;
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
      // Every exchange leaves its chip select level on the line.
      if (res_valid && kind_nxt == KIND_EXCHANGE) begin
        sel_nxt = cs_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      frame_idx_r <= '0;
      busy_cnt_r  <= '0;
      retries_r   <= '0;
      cmd_r       <= '0;
      arg_r       <= '0;
      crc_r       <= '0;
      sel_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      frame_idx_r <= frame_idx_nxt;
      busy_cnt_r  <= busy_cnt_nxt;
      retries_r   <= retries_nxt;
      cmd_r       <= cmd_nxt;
      arg_r       <= arg_nxt;
      crc_r       <= crc_nxt;
      sel_r       <= sel_nxt;
      if (in_acc && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      kind_r <= kind_nxt;
      tx_r   <= tx_nxt;
      cs_r   <= cs_nxt;
      r1_r   <= r1_nxt;
      fail_r <= fail_nxt;
    end
  end

  // A start word is always answered by a deselected dummy exchange.
  a_start_deselects: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.func == FUNC_START) |=>
      (out_valid_r && kind_r == KIND_EXCHANGE && tx_r == IDLE_BYTE && cs_r))
    else $error("start word not answered by a deselected dummy exchange");

  // A failed select always reports an all-ones R1 byte.
  a_fail_r1: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == KIND_FINISH && fail_r) |-> (r1_r == IDLE_BYTE))
    else $error("failed select with R1 other than 0xFF");

  // Exchange words carry no response and no failure flag.
  a_exchange_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == KIND_EXCHANGE) |-> (r1_r == '0 && !fail_r))
    else $error("exchange word carries response fields");

  // The engine returns to idle right after it emits a finished word.
  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && res_valid && kind_nxt == KIND_FINISH) |=> (phase_r == PH_IDLE))
    else $error("engine not idle after a finished word");

endmodule

`default_nettype wire
